/* rtl/fir_pkg.sv */
// fir_pkg: shared types, constants and the fixed coefficient table of the
// 23-tap Q15 FIR. No dependencies.
`default_nettype none

package fir_pkg;

  // Sample and coefficient formats.
  localparam int SAMPLE_BITS = 16;
  localparam int COEFF_W     = 16;
  localparam int FRAC_BITS   = 15;

  // Digit-serial multiply: the sample is fed MSB digit first.
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = (SAMPLE_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int DIG_CNT_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int EXT_W      = NUM_DIGITS * DIGIT_W;
  localparam int PROD_W     = COEFF_W + DIGIT_W + 1;
  localparam int PART_W     = COEFF_W + EXT_W;
  // Headroom for up to 64 taps plus one guard bit.
  localparam int ACC_W      = PART_W + 7;

  // Coefficient table; taps past the fixed set read as zero.
  localparam int NUM_FIXED = 23;
  localparam int IDX_W     = 6;
  localparam int FIX_IDX_W = 5;

  localparam logic signed [COEFF_W-1:0] LOWPASS [NUM_FIXED] = '{
    16'sd434,   16'sd143,   -16'sd738,  -16'sd1193, -16'sd153,  16'sd1287,
    16'sd682,   -16'sd1940, -16'sd2591, 16'sd2233,  16'sd10089, 16'sd13988,
    16'sd10089, 16'sd2233,  -16'sd2591, -16'sd1940, 16'sd682,   16'sd1287,
    -16'sd153,  -16'sd1193, -16'sd738,  16'sd143,   16'sd434
  };

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } fir_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered_left;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } fir_out_t;

  // Sequencer to MAC control group.
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic step;   // process one digit
    logic load;   // first digit of a tap: take a new sample
    logic last;   // last digit of a tap: fold product into accumulator
  } mac_ctrl_t;

  function automatic logic signed [COEFF_W-1:0] coeff_at(input logic [IDX_W-1:0] idx);
    logic signed [COEFF_W-1:0] c;
    c = '0;
    if (idx < IDX_W'(NUM_FIXED)) begin
      c = LOWPASS[idx[FIX_IDX_W-1:0]];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/fir_dline.sv */
// fir_dline: rotating sample delay line of the FIR.
// Depends on fir_pkg.
`default_nettype none

module fir_dline #(
  parameter int TAPS = 23
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    push_i,
  input  wire logic                                    rot_i,
  input  wire logic signed [fir_pkg::SAMPLE_BITS-1:0]  sample_i,
  output logic signed [fir_pkg::SAMPLE_BITS-1:0]       head_o
);
  import fir_pkg::*;

  logic signed [SAMPLE_BITS-1:0] line_q [TAPS];
  logic signed [SAMPLE_BITS-1:0] line_d [TAPS];

  // push: newest at tap 0. rot: shift toward tap 0, tap 0 wraps to the end,
  // so TAPS rotations restore the line.
  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      line_d[j] = line_q[j];
    end
    if (push_i) begin
      line_d[0] = sample_i;
      for (int j = 1; j < TAPS; j++) begin
        line_d[j] = line_q[j-1];
      end
    end else if (rot_i) begin
      for (int j = 0; j < TAPS - 1; j++) begin
        line_d[j] = line_q[j+1];
      end
      line_d[TAPS-1] = line_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TAPS; j++) begin
        line_q[j] <= '0;
      end
    end else begin
      for (int j = 0; j < TAPS; j++) begin
        line_q[j] <= line_d[j];
      end
    end
  end

  assign head_o = line_q[0];

endmodule

`default_nettype wire

/* rtl/fir_dsmac.sv */
// fir_dsmac: digit-serial multiply-accumulate, one sample digit per cycle of step.
// Depends on fir_pkg.
`default_nettype none

module fir_dsmac (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire fir_pkg::mac_ctrl_t                    ctrl_i,
  input  wire logic signed [fir_pkg::SAMPLE_BITS-1:0] sample_i,
  input  wire logic signed [fir_pkg::COEFF_W-1:0]     coeff_i,
  output logic signed [fir_pkg::ACC_W-1:0]            acc_o
);
  import fir_pkg::*;

  logic [EXT_W-1:0]               dig_q, dig_d, src;
  logic [DIGIT_W-1:0]             digit;
  logic signed [DIGIT_W:0]        digit_s;
  logic signed [PROD_W-1:0]       prod;
  logic signed [PART_W-1:0]       part_q, part_d, part_sh;
  logic signed [ACC_W-1:0]        acc_q;
  logic                           add_q;

  always_comb begin
    src   = ctrl_i.load ? EXT_W'(sample_i) : dig_q;
    digit = src[EXT_W-1 -: DIGIT_W];
    dig_d = {src[EXT_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    // MSB digit carries the sign, the rest are unsigned
    digit_s = ctrl_i.load ? {digit[DIGIT_W-1], digit} : {1'b0, digit};
    prod    = PROD_W'(coeff_i) * PROD_W'(digit_s);
    part_sh = ctrl_i.load ? '0 : (part_q <<< DIGIT_W);
    part_d  = part_sh + PART_W'(prod);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      dig_q  <= dig_d;
      part_q <= part_d;
    end
  end

  // After its last digit, the tap product goes from part_q into the accumulator via add_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_q <= 1'b0;
      acc_q <= '0;
    end else begin
      add_q <= ctrl_i.step & ctrl_i.last;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (add_q) begin
        acc_q <= acc_q + ACC_W'(part_q);
      end
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* rtl/fir_filter_23tap_q15.sv */
// fir_filter_23tap_q15: stereo beat in, left channel through a TAPS-tap Q15
// FIR, right channel passed through. Depends on fir_pkg, fir_dline, fir_dsmac.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+----------------------------------
//   input   | in_valid_i  | in_ready_o  | in_data_i  (left, right sample)
//   output  | out_valid_o | out_ready_i | out_data_o (filtered left, right)
//
// For each beat the shared digit-serial MAC handles one 4-bit sample digit per
// cycle, tap by tap, before the drain and finish states.
// in_ready_o is high only while the sequencer is idle; the output register
// lets a new beat start while the previous result still waits.
// A stalled output holds the finished result in the sequencer until the
// output register frees up. Reset clears the delay line and all control.
`default_nettype none

module fir_filter_23tap_q15 #(
  parameter int TAPS = 23
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fir_pkg::fir_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output fir_pkg::fir_out_t      out_data_o
);
  import fir_pkg::*;

  localparam int TCW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int QW  = ACC_W - FRAC_BITS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [TCW-1:0]          tcnt_q, tcnt_d;
  logic [DIG_CNT_W-1:0]    dcnt_q, dcnt_d;
  logic                    in_acc, out_load;
  logic                    dig_first, dig_last, tap_last;
  mac_ctrl_t               mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] head;
  logic signed [COEFF_W-1:0]     coeff;
  logic signed [ACC_W-1:0]       acc;
  logic signed [QW-1:0]          qval;
  logic [QW-SAMPLE_BITS:0]       qtop;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic signed [SAMPLE_BITS-1:0] right_q;
  logic                          out_valid_q;
  fir_out_t                      out_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_load   = (state_q == S_FIN) & (~out_valid_q | out_ready_i);

  assign dig_first = (dcnt_q == '0);
  assign dig_last  = (dcnt_q == DIG_CNT_W'(NUM_DIGITS - 1));
  assign tap_last  = (tcnt_q == TCW'(TAPS - 1));

  // Sequencer: taps in order, digits MSB first within each tap.
  always_comb begin
    state_d = state_q;
    tcnt_d  = tcnt_q;
    dcnt_d  = dcnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RUN;
          tcnt_d  = '0;
          dcnt_d  = '0;
        end
      end
      S_RUN: begin
        if (dig_last) begin
          dcnt_d = '0;
          tcnt_d = tcnt_q + TCW'(1);
          if (tap_last) begin
            state_d = S_DRAIN;
          end
        end else begin
          dcnt_d = dcnt_q + DIG_CNT_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    mac_ctrl.clear = in_acc;
    mac_ctrl.step  = (state_q == S_RUN);
    mac_ctrl.load  = dig_first;
    mac_ctrl.last  = dig_last;
  end

  assign coeff = coeff_at(IDX_W'(tcnt_q));

  fir_dline #(
    .TAPS (TAPS)
  ) u_dline (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_acc),
    .rot_i    (mac_ctrl.step & dig_first),
    .sample_i (in_data_i.left_sample),
    .head_o   (head)
  );

  fir_dsmac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (head),
    .coeff_i  (coeff),
    .acc_o    (acc)
  );

  // Arithmetic shift by FRAC_BITS, then clamp to the sample range.
  always_comb begin
    qval = acc[ACC_W-1:FRAC_BITS];
    qtop = qval[QW-1:SAMPLE_BITS-1];
    if ((&qtop) || !(|qtop)) begin
      sat = qval[SAMPLE_BITS-1:0];
    end else if (qval[QW-1]) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tcnt_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tcnt_q  <= tcnt_d;
      dcnt_q  <= dcnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      right_q <= in_data_i.right_sample;
    end
    if (out_load) begin
      out_q.filtered_left <= sat;
      out_q.right_out     <= right_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Accepted beat always starts the MAC sequence.
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_RUN) && (tcnt_q == '0) && (dcnt_q == '0))
    else $error("accepted beat did not start the tap sequence");

  // Tap and digit counters never leave their ranges while running.
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (tcnt_q <= TCW'(TAPS - 1)) &&
                           (dcnt_q <= DIG_CNT_W'(NUM_DIGITS - 1)))
    else $error("tap or digit counter out of range");

  // A finished result that moves to the output register shows as valid, and the sequencer is idle.
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && (state_q == S_IDLE))
    else $error("finished result not presented");

  // No new beat is taken while the sequencer is busy.
  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input ready while busy");

endmodule

`default_nettype wire
